// ===== src/tpia_pkg.sv =====
package tpia_pkg;

    localparam int LINE_COUNT = 5;
    localparam logic [7:0] NONE_PENDING = 8'hff;
    localparam logic [7:0] PIN_RESET = 8'hff;

    // Control register bit positions.
    localparam int CTRL_IRQ_MODE = 0;
    localparam int CTRL_PRIORITY = 1;
    localparam int CTRL_EDGE_3 = 2;
    localparam int CTRL_EDGE_4 = 3;
    localparam int CTRL_CA_VAL = 4;
    localparam int CTRL_CA_SET = 5;
    localparam int CTRL_CB_VAL = 6;
    localparam int CTRL_CB_SET = 7;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_LINE  = 2'd2,
        MODE_PIN   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_PORT_A  = 3'd0,
        REG_PORT_B  = 3'd1,
        REG_PORT_C  = 3'd2,
        REG_DDR_A   = 3'd3,
        REG_DDR_B   = 3'd4,
        REG_DDR_C   = 3'd5,
        REG_CONTROL = 3'd6,
        REG_IRQ     = 3'd7
    } t_reg_addr;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] reg_addr;
        logic [7:0] write_data;
        logic [2:0] line_index;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
        logic [7:0] port_c_out;
        logic       port_c_driven;
        logic       irq_out;
        logic       ca_out;
        logic       cb_out;
    } t_result;

endpackage

// ===== src/tpia_core.sv =====
module tpia_core
    import tpia_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    logic [7:0] r_ctrl, n_ctrl;
    logic [LINE_COUNT-1:0] r_pend, n_pend;
    logic [LINE_COUNT-1:0] r_levels, n_levels;
    logic [7:0] r_ddr_a, n_ddr_a, r_ddr_b, n_ddr_b, r_ddr_c, n_ddr_c;
    logic [7:0] r_out_a, n_out_a, r_out_b, n_out_b, r_out_c, n_out_c;
    logic [7:0] r_pin_a, n_pin_a, r_pin_b, n_pin_b, r_pin_c, n_pin_c;
    logic r_ca, n_ca, r_cb, n_cb;

    logic [7:0] w_rd;
    logic [LINE_COUNT-1:0] w_line_bit;
    logic [LINE_COUNT-1:0] w_highest;
    logic w_old_level;
    logic w_trig;

    function automatic logic [7:0] merge(input logic [7:0] pins, input logic [7:0] ddr,
                                         input logic [7:0] latch);
        return (pins & ~ddr) | (latch & ddr);
    endfunction

    always_comb begin
        w_highest = '0;
        for (int k = 0; k < LINE_COUNT; k++) begin
            if (r_pend[k]) begin
                w_highest = LINE_COUNT'(1) << k;
            end
        end
    end

    // An index beyond the last line shifts out to an empty mask.
    assign w_line_bit = LINE_COUNT'(1) << i_item.line_index;
    assign w_old_level = |(r_levels & w_line_bit);

    always_comb begin
        case (i_item.line_index)
            3'd3: w_trig = r_ctrl[CTRL_EDGE_3] ? i_item.line_level : !i_item.line_level;
            3'd4: w_trig = r_ctrl[CTRL_EDGE_4] ? i_item.line_level : !i_item.line_level;
            default: w_trig = !i_item.line_level;
        endcase
    end

    always_comb begin
        n_ctrl = r_ctrl;
        n_pend = r_pend;
        n_levels = r_levels;
        n_ddr_a = r_ddr_a;
        n_ddr_b = r_ddr_b;
        n_ddr_c = r_ddr_c;
        n_out_a = r_out_a;
        n_out_b = r_out_b;
        n_out_c = r_out_c;
        n_pin_a = r_pin_a;
        n_pin_b = r_pin_b;
        n_pin_c = r_pin_c;
        n_ca = r_ca;
        n_cb = r_cb;
        w_rd = '0;
        case (t_mode'(i_item.mode))
            MODE_READ: begin
                case (t_reg_addr'(i_item.reg_addr))
                    REG_PORT_A: w_rd = merge(r_pin_a, r_ddr_a, r_out_a);
                    REG_PORT_B: w_rd = merge(r_pin_b, r_ddr_b, r_out_b);
                    REG_PORT_C: begin
                        if (r_ctrl[CTRL_IRQ_MODE]) begin
                            w_rd = {r_cb, r_ca, ~(|r_pend), r_levels};
                        end else begin
                            w_rd = merge(r_pin_c, r_ddr_c, r_out_c);
                        end
                    end
                    REG_DDR_A: w_rd = r_ddr_a;
                    REG_DDR_B: w_rd = r_ddr_b;
                    REG_DDR_C: w_rd = r_ddr_c;
                    REG_CONTROL: w_rd = r_ctrl;
                    REG_IRQ: begin
                        if (r_ctrl[CTRL_PRIORITY]) begin
                            if (|r_pend) begin
                                w_rd = {3'b000, w_highest};
                                n_pend = r_pend & ~w_highest;
                            end else begin
                                w_rd = NONE_PENDING;
                            end
                        end else begin
                            w_rd = {3'b000, r_pend};
                            n_pend = '0;
                        end
                    end
                    default: w_rd = '0;
                endcase
            end
            MODE_WRITE: begin
                case (t_reg_addr'(i_item.reg_addr))
                    REG_PORT_A: n_out_a = i_item.write_data;
                    REG_PORT_B: n_out_b = i_item.write_data;
                    REG_PORT_C: n_out_c = i_item.write_data;
                    REG_DDR_A: n_ddr_a = i_item.write_data;
                    REG_DDR_B: n_ddr_b = i_item.write_data;
                    REG_DDR_C: n_ddr_c = i_item.write_data;
                    REG_CONTROL: begin
                        n_ctrl = i_item.write_data;
                        if (i_item.write_data[CTRL_IRQ_MODE]) begin
                            if (i_item.write_data[CTRL_CA_SET]) begin
                                n_ca = i_item.write_data[CTRL_CA_VAL];
                            end
                            if (i_item.write_data[CTRL_CB_SET]) begin
                                n_cb = i_item.write_data[CTRL_CB_VAL];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_LINE: begin
                if (r_ctrl[CTRL_IRQ_MODE] && (|w_line_bit)
                        && (w_old_level != i_item.line_level)) begin
                    n_levels = i_item.line_level ? (r_levels | w_line_bit)
                                                 : (r_levels & ~w_line_bit);
                    if (w_trig && (|(r_ddr_c[LINE_COUNT-1:0] & w_line_bit))) begin
                        n_pend = r_pend | w_line_bit;
                    end
                end
            end
            MODE_PIN: begin
                case (t_reg_addr'(i_item.reg_addr))
                    REG_PORT_A: n_pin_a = i_item.write_data;
                    REG_PORT_B: n_pin_b = i_item.write_data;
                    REG_PORT_C: n_pin_c = i_item.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
            r_pend <= '0;
            r_levels <= '0;
            r_ddr_a <= '0;
            r_ddr_b <= '0;
            r_ddr_c <= '0;
            r_out_a <= '0;
            r_out_b <= '0;
            r_out_c <= '0;
            r_pin_a <= PIN_RESET;
            r_pin_b <= PIN_RESET;
            r_pin_c <= PIN_RESET;
            r_ca <= 1'b0;
            r_cb <= 1'b0;
        end else if (i_step) begin
            r_ctrl <= n_ctrl;
            r_pend <= n_pend;
            r_levels <= n_levels;
            r_ddr_a <= n_ddr_a;
            r_ddr_b <= n_ddr_b;
            r_ddr_c <= n_ddr_c;
            r_out_a <= n_out_a;
            r_out_b <= n_out_b;
            r_out_c <= n_out_c;
            r_pin_a <= n_pin_a;
            r_pin_b <= n_pin_b;
            r_pin_c <= n_pin_c;
            r_ca <= n_ca;
            r_cb <= n_cb;
        end
    end

    // The result shows the state as it stands after this item.
    always_comb begin
        o_result.read_data = w_rd;
        o_result.port_a_out = n_out_a & n_ddr_a;
        o_result.port_b_out = n_out_b & n_ddr_b;
        o_result.port_c_out = n_out_c & n_ddr_c;
        o_result.port_c_driven = !n_ctrl[CTRL_IRQ_MODE];
        o_result.irq_out = |n_pend;
        o_result.ca_out = n_ca;
        o_result.cb_out = n_cb;
    end

endmodule

// ===== src/triple_port_interface_adapter.sv =====
// An accepted item waits in the input register, and its result is registered in the result
// register once the output is free. Throughput: one item per cycle while the output is not
// stalled; each register holds one item, and the state update in between is a single level
// of register muxing. Reset: synchronous, active low; clears both valid flags and all port,
// direction, control and interrupt state, and sets the pin latches to all ones.
module triple_port_interface_adapter
    import tpia_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic [2:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic [2:0] i_line_index,
    input  logic       i_line_level,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic [7:0] o_port_a_out,
    output logic [7:0] o_port_b_out,
    output logic [7:0] o_port_c_out,
    output logic       o_port_c_driven,
    output logic       o_irq_out,
    output logic       o_ca_out,
    output logic       o_cb_out
);

    // Input stage: the accepted item waits here until the result register can take
    // its result. The item is applied to the state in the same cycle that its result
    // is captured, so the state and the results stay in item order.
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result w_result;
    logic    w_advance;

    // The result register is free when it is empty or its item leaves this cycle.
    assign w_advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.mode <= i_mode;
            r_item.reg_addr <= i_reg_addr;
            r_item.write_data <= i_write_data;
            r_item.line_index <= i_line_index;
            r_item.line_level <= i_line_level;
        end
    end

    // All register, port and interrupt state lives in the core, which is stepped
    // exactly once for each item that moves into the result register.
    tpia_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_result.read_data;
    assign o_port_a_out = r_result.port_a_out;
    assign o_port_b_out = r_result.port_b_out;
    assign o_port_c_out = r_result.port_c_out;
    assign o_port_c_driven = r_result.port_c_driven;
    assign o_irq_out = r_result.irq_out;
    assign o_ca_out = r_result.ca_out;
    assign o_cb_out = r_result.cb_out;

endmodule

// ===== src/tpia_checker.sv =====
module tpia_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_data,
    input logic       o_irq_out
);

    // The input side only stalls while a finished result is held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    // Coming out of reset the block is empty and ready.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && o_in_ready))
        else $error("block not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_read_data) && $stable(o_irq_out)))
        else $error("stalled result changed");

endmodule

bind triple_port_interface_adapter tpia_checker u_tpia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_read_data (o_read_data),
    .o_irq_out   (o_irq_out)
);
